>>> hdl/aat_pkg.sv
`default_nettype none

package aat_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int MATRIX_ENTRY_WIDTH = 20;
	localparam int FRAC_BITS = 16;
	localparam int AXES = 3;

	localparam int ROW_WIDTH = AXES * MATRIX_ENTRY_WIDTH;
	localparam int CFG_DATA_WIDTH = (ROW_WIDTH > COORD_WIDTH) ? ROW_WIDTH : COORD_WIDTH;
	localparam int CFG_INDEX_WIDTH = 3;

	localparam int SUM_WIDTH = COORD_WIDTH + 1;
	localparam int EXT_WIDTH = COORD_WIDTH;
	localparam int PROD_C_WIDTH = SUM_WIDTH + MATRIX_ENTRY_WIDTH;
	localparam int PROD_E_WIDTH = EXT_WIDTH + MATRIX_ENTRY_WIDTH;
	localparam int ACC_C_WIDTH = PROD_C_WIDTH + 2;
	localparam int ACC_E_WIDTH = PROD_E_WIDTH + 2;
	localparam int RND_WIDTH = ACC_C_WIDTH + 1;
	localparam int SCL_WIDTH = RND_WIDTH - FRAC_BITS - 1;
	localparam int PRE_WIDTH = ((SCL_WIDTH > COORD_WIDTH) ? SCL_WIDTH : COORD_WIDTH) + 1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [MATRIX_ENTRY_WIDTH-1:0] entry_t;
	typedef logic signed [SUM_WIDTH-1:0] sum_t;
	typedef logic [EXT_WIDTH-1:0] ext_t;
	typedef logic signed [ACC_C_WIDTH-1:0] acc_c_t;
	typedef logic [ACC_E_WIDTH-1:0] acc_e_t;
	typedef logic signed [SCL_WIDTH-1:0] scl_t;
	typedef logic [ROW_WIDTH-1:0] row_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_ROW_X   = 3'd0,
		REG_ROW_Y   = 3'd1,
		REG_ROW_Z   = 3'd2,
		REG_SHIFT_X = 3'd3,
		REG_SHIFT_Y = 3'd4,
		REG_SHIFT_Z = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	localparam entry_t MAT_ONE = MATRIX_ENTRY_WIDTH'(1 << FRAC_BITS);
	localparam logic signed [RND_WIDTH-1:0] ROUND_BIAS = RND_WIDTH'(1 << FRAC_BITS);
	localparam logic signed [PRE_WIDTH-1:0] PRE_MAX =
		PRE_WIDTH'({1'b0, {(COORD_WIDTH-1){1'b1}}});
	localparam logic signed [PRE_WIDTH-1:0] PRE_MIN = ~PRE_MAX;

endpackage

`default_nettype wire

>>> hdl/aabb_affine_transform_unit.sv
// Affine transform of an axis-aligned box. Each input beat carries one box as its
// minimum and maximum corners (signed Q16.16); each output beat carries the box that
// bounds its image under the programmed map, plus a flag set when any coordinate
// saturated. Both channels use valid/stall; a beat moves when valid is high and
// stall is low.
// The map is programmed through a write-only port: indexes 0 to 2 take the three
// matrix rows (three signed Q4.16 entries each), 3 to 5 the translation. Writes to
// other indexes are dropped. Program it only while no box is in flight.
// The datapath is five register stages: extent and center sums, the eighteen
// products, their accumulation per axis, rounding, then translation and saturation
// into the output register. One box is accepted every cycle while in_stall is low.
// When the receiver stalls, each stage holds only if the stage after it is full,
// so bubbles close up and input is stalled only when all five stages hold a box.
// Reset clears the pipeline and loads the identity map with zero translation.
`default_nettype none

module aabb_affine_transform_unit
	import aat_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire coord_t                     lo_x,
	input  wire coord_t                     lo_y,
	input  wire coord_t                     lo_z,
	input  wire coord_t                     hi_x,
	input  wire coord_t                     hi_y,
	input  wire coord_t                     hi_z,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output coord_t                          new_lo_x,
	output coord_t                          new_lo_y,
	output coord_t                          new_lo_z,
	output coord_t                          new_hi_x,
	output coord_t                          new_hi_y,
	output coord_t                          new_hi_z,
	output logic                            clipped,
	input  wire logic                       cfg_wr_en,
	input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

	row_t   row_q [AXES];
	coord_t shift_q [AXES];

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	stage_en_t en;

	coord_t lo_in [AXES];
	coord_t hi_in [AXES];
	sum_t   sum_s1 [AXES];
	ext_t   ext_s1 [AXES];
	entry_t col_m [AXES][AXES];
	acc_c_t acc_c_s3 [AXES];
	acc_e_t acc_e_s3 [AXES];
	coord_t lo_s5 [AXES];
	coord_t hi_s5 [AXES];
	logic   clip_s5 [AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < AXES; j++) begin
				row_q[j] <= row_t'({MAT_ONE}) << (j*MATRIX_ENTRY_WIDTH);
				shift_q[j] <= '0;
			end
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ROW_X:   row_q[0] <= cfg_data[ROW_WIDTH-1:0];
				REG_ROW_Y:   row_q[1] <= cfg_data[ROW_WIDTH-1:0];
				REG_ROW_Z:   row_q[2] <= cfg_data[ROW_WIDTH-1:0];
				REG_SHIFT_X: shift_q[0] <= cfg_data[COORD_WIDTH-1:0];
				REG_SHIFT_Y: shift_q[1] <= cfg_data[COORD_WIDTH-1:0];
				REG_SHIFT_Z: shift_q[2] <= cfg_data[COORD_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign en.s5 = !valid_s5 || !out_stall;
	assign en.s4 = !valid_s4 || en.s5;
	assign en.s3 = !valid_s3 || en.s4;
	assign en.s2 = !valid_s2 || en.s3;
	assign en.s1 = !valid_s1 || en.s2;
	assign in_stall = !en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= in_valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
			if (en.s5) valid_s5 <= valid_s4;
		end
	end

	assign lo_in[0] = lo_x;
	assign lo_in[1] = lo_y;
	assign lo_in[2] = lo_z;
	assign hi_in[0] = hi_x;
	assign hi_in[1] = hi_y;
	assign hi_in[2] = hi_z;

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			for (int j = 0; j < AXES; j++) begin
				col_m[i][j] = row_q[j][i*MATRIX_ENTRY_WIDTH +: MATRIX_ENTRY_WIDTH];
			end
		end
	end

	aat_prep u_prep (
		.clk    (clk),
		.en     (en.s1),
		.lo     (lo_in),
		.hi     (hi_in),
		.sum_s1 (sum_s1),
		.ext_s1 (ext_s1)
	);

	for (genvar i = 0; i < AXES; i++) begin : g_axis
		aat_mac u_mac (
			.clk      (clk),
			.en       (en),
			.sum_s1   (sum_s1),
			.ext_s1   (ext_s1),
			.m        (col_m[i]),
			.acc_c_s3 (acc_c_s3[i]),
			.acc_e_s3 (acc_e_s3[i])
		);

		aat_fin u_fin (
			.clk      (clk),
			.en       (en),
			.acc_c_s3 (acc_c_s3[i]),
			.acc_e_s3 (acc_e_s3[i]),
			.shift    (shift_q[i]),
			.lo_s5    (lo_s5[i]),
			.hi_s5    (hi_s5[i]),
			.clip_s5  (clip_s5[i])
		);
	end

	assign out_valid = valid_s5;
	assign new_lo_x = lo_s5[0];
	assign new_lo_y = lo_s5[1];
	assign new_lo_z = lo_s5[2];
	assign new_hi_x = hi_s5[0];
	assign new_hi_y = hi_s5[1];
	assign new_hi_z = hi_s5[2];
	assign clipped = clip_s5[0] | clip_s5[1] | clip_s5[2];

	// Input is held back only when every stage is occupied and the output is stalled.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 && out_stall))
		else $error("input stalled while the pipeline has room");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted box did not enter the first stage");

	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !valid_s4) |=> !out_valid)
		else $error("output beat repeated after it was taken");

endmodule

`default_nettype wire

>>> hdl/aat_prep.sv
`default_nettype none

module aat_prep
	import aat_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   en,
	input  wire coord_t lo [AXES],
	input  wire coord_t hi [AXES],
	output sum_t        sum_s1 [AXES],
	output ext_t        ext_s1 [AXES]
);

	sum_t sum_d [AXES];
	ext_t ext_d [AXES];

	always_comb begin
		sum_t diff;
		sum_t mag;
		diff = '0;
		mag = '0;
		for (int j = 0; j < AXES; j++) begin
			sum_d[j] = SUM_WIDTH'(lo[j]) + SUM_WIDTH'(hi[j]);
			diff = SUM_WIDTH'(hi[j]) - SUM_WIDTH'(lo[j]);
			mag = (diff < 0) ? -diff : diff;
			ext_d[j] = mag[EXT_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1 <= sum_d;
			ext_s1 <= ext_d;
		end
	end

endmodule

`default_nettype wire

>>> hdl/aat_mac.sv
`default_nettype none

module aat_mac
	import aat_pkg::*;
(
	input  wire logic      clk,
	input  wire stage_en_t en,
	input  wire sum_t      sum_s1 [AXES],
	input  wire ext_t      ext_s1 [AXES],
	input  wire entry_t    m [AXES],
	output acc_c_t         acc_c_s3,
	output acc_e_t         acc_e_s3
);

	logic signed [PROD_C_WIDTH-1:0] prod_c_s2 [AXES];
	logic [PROD_E_WIDTH-1:0]        prod_e_s2 [AXES];

	always_ff @(posedge clk) begin
		logic [MATRIX_ENTRY_WIDTH-1:0] am;
		if (en.s2) begin
			for (int j = 0; j < AXES; j++) begin
				am = (m[j] < 0) ? MATRIX_ENTRY_WIDTH'(-m[j]) : MATRIX_ENTRY_WIDTH'(m[j]);
				prod_c_s2[j] <= PROD_C_WIDTH'(sum_s1[j]) * PROD_C_WIDTH'(m[j]);
				prod_e_s2[j] <= PROD_E_WIDTH'(ext_s1[j]) * PROD_E_WIDTH'(am);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			acc_c_s3 <= ACC_C_WIDTH'(prod_c_s2[0]) + ACC_C_WIDTH'(prod_c_s2[1])
				+ ACC_C_WIDTH'(prod_c_s2[2]);
			acc_e_s3 <= ACC_E_WIDTH'(prod_e_s2[0]) + ACC_E_WIDTH'(prod_e_s2[1])
				+ ACC_E_WIDTH'(prod_e_s2[2]);
		end
	end

endmodule

`default_nettype wire

>>> hdl/aat_fin.sv
`default_nettype none

module aat_fin
	import aat_pkg::*;
(
	input  wire logic      clk,
	input  wire stage_en_t en,
	input  wire acc_c_t    acc_c_s3,
	input  wire acc_e_t    acc_e_s3,
	input  wire coord_t    shift,
	output coord_t         lo_s5,
	output coord_t         hi_s5,
	output logic           clip_s5
);

	logic signed [RND_WIDTH-1:0] c_ext;
	logic signed [RND_WIDTH-1:0] e_ext;
	logic signed [RND_WIDTH-1:0] hi_sum;
	logic signed [RND_WIDTH-1:0] lo_sum;
	scl_t scl_hi_s4;
	scl_t scl_lo_s4;
	logic signed [PRE_WIDTH-1:0] pre_hi;
	logic signed [PRE_WIDTH-1:0] pre_lo;
	logic hi_over, hi_under, lo_over, lo_under;

	assign c_ext = RND_WIDTH'(acc_c_s3);
	assign e_ext = $signed(RND_WIDTH'(acc_e_s3));
	assign hi_sum = c_ext + e_ext + ROUND_BIAS;
	assign lo_sum = c_ext - e_ext + ROUND_BIAS;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			scl_hi_s4 <= hi_sum[RND_WIDTH-1:FRAC_BITS+1];
			scl_lo_s4 <= lo_sum[RND_WIDTH-1:FRAC_BITS+1];
		end
	end

	assign pre_hi = PRE_WIDTH'(scl_hi_s4) + PRE_WIDTH'(shift);
	assign pre_lo = PRE_WIDTH'(scl_lo_s4) + PRE_WIDTH'(shift);
	assign hi_over = pre_hi > PRE_MAX;
	assign hi_under = pre_hi < PRE_MIN;
	assign lo_over = pre_lo > PRE_MAX;
	assign lo_under = pre_lo < PRE_MIN;

	always_ff @(posedge clk) begin
		if (en.s5) begin
			hi_s5 <= hi_over ? PRE_MAX[COORD_WIDTH-1:0] :
				hi_under ? PRE_MIN[COORD_WIDTH-1:0] : pre_hi[COORD_WIDTH-1:0];
			lo_s5 <= lo_over ? PRE_MAX[COORD_WIDTH-1:0] :
				lo_under ? PRE_MIN[COORD_WIDTH-1:0] : pre_lo[COORD_WIDTH-1:0];
			clip_s5 <= hi_over | hi_under | lo_over | lo_under;
		end
	end

endmodule

`default_nettype wire
